// ===== design/ps2mt_pkg.sv =====
// Shared types and constants for the PS/2 mouse packet tracker.
// No dependencies; used by every module in the design folder.
package ps2mt_pkg;

   localparam int CoordW      = 13;   // cursor coordinate and screen size width
   localparam int SumW        = 15;   // signed working width for move and bound
   localparam int DefCursorW  = 8;
   localparam int DefCursorH  = 8;

   localparam logic [CoordW-1:0] ResetWidth  = 13'd1024;
   localparam logic [CoordW-1:0] ResetHeight = 13'd768;
   localparam logic [CoordW-1:0] ResetPosX   = 13'd40;
   localparam logic [CoordW-1:0] ResetPosY   = 13'd12;

   // status byte bit positions
   localparam int BitSync = 3;
   localparam int BitXSgn = 4;
   localparam int BitYSgn = 5;
   localparam int BitXOvf = 6;
   localparam int BitYOvf = 7;

   typedef enum logic [1:0] {
      PHASE_FIRST  = 2'd0,
      PHASE_SECOND = 2'd1,
      PHASE_THIRD  = 2'd2
   } phase_type;

   typedef enum logic [0:0] {
      CSR_SCREEN_WIDTH  = 1'b0,
      CSR_SCREEN_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic              ignored;
      logic              discarded;
      logic              applied;
      logic [2:0]        buttons;   // middle, right, left
      logic [CoordW-1:0] cursor_y;
      logic [CoordW-1:0] cursor_x;
   } result_type;

endpackage

// ===== design/ps2mt_axis_clamp.sv =====
// Clamp of one moved coordinate to [0, screen - cursor].
// Depends on ps2mt_pkg for widths.
module ps2mt_axis_clamp #(
   parameter int CURSOR = ps2mt_pkg::DefCursorW
) (
   input  logic signed [ps2mt_pkg::SumW-1:0]   moved,
   input  logic        [ps2mt_pkg::CoordW-1:0] screen,
   output logic        [ps2mt_pkg::CoordW-1:0] clamped
);
   import ps2mt_pkg::*;

   localparam logic signed [SumW-1:0] CursorS = SumW'(CURSOR);

   logic signed [SumW-1:0] bound;
   logic signed [SumW-1:0] floor_v;
   logic signed [SumW-1:0] result;

   always_comb begin
      bound = $signed({{(SumW-CoordW){1'b0}}, screen}) - CursorS;
      if (bound < 0) begin
         bound = '0;
      end
      floor_v = (moved < 0) ? '0 : moved;
      result  = (floor_v >= bound) ? bound : floor_v;
      clamped = result[CoordW-1:0];
   end

endmodule

// ===== design/ps2mt_decoder.sv =====
// Packet assembly state, position update and button refresh.
// Depends on ps2mt_pkg and ps2mt_axis_clamp.
module ps2mt_decoder #(
   parameter int CURSOR_W = ps2mt_pkg::DefCursorW,
   parameter int CURSOR_H = ps2mt_pkg::DefCursorH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic [7:0]                     rx_byte,
   input  logic [ps2mt_pkg::CoordW-1:0]   screen_width,
   input  logic [ps2mt_pkg::CoordW-1:0]   screen_height,
   output ps2mt_pkg::result_type          result
);
   import ps2mt_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [7:0]        first_ff, first_in;
   logic [7:0]        second_ff, second_in;
   logic [CoordW-1:0] pos_x_ff, pos_x_in;
   logic [CoordW-1:0] pos_y_ff, pos_y_in;
   logic [2:0]        buttons_ff, buttons_in;
   logic              applied, discarded, ignored;

   logic signed [SumW-1:0] dx, dy, moved_x, moved_y;
   logic [CoordW-1:0]      clamp_x, clamp_y;

   always_comb begin
      dx = $signed({{(SumW-8){1'b0}}, second_ff}) -
           (first_ff[BitXSgn] ? SumW'(256) : SumW'(0));
      dy = $signed({{(SumW-8){1'b0}}, rx_byte}) -
           (first_ff[BitYSgn] ? SumW'(256) : SumW'(0));
      moved_x = $signed({{(SumW-CoordW){1'b0}}, pos_x_ff}) + dx;
      moved_y = $signed({{(SumW-CoordW){1'b0}}, pos_y_ff}) - dy;
   end

   ps2mt_axis_clamp #(.CURSOR(CURSOR_W)) u_clamp_x (
      .moved   (moved_x),
      .screen  (screen_width),
      .clamped (clamp_x)
   );

   ps2mt_axis_clamp #(.CURSOR(CURSOR_H)) u_clamp_y (
      .moved   (moved_y),
      .screen  (screen_height),
      .clamped (clamp_y)
   );

   always_comb begin
      phase_in   = phase_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      buttons_in = buttons_ff;
      applied    = 1'b0;
      discarded  = 1'b0;
      ignored    = 1'b0;
      unique case (phase_ff)
         PHASE_SECOND: begin
            second_in  = rx_byte;
            phase_in   = PHASE_THIRD;
            buttons_in = first_ff[2:0];
         end
         PHASE_THIRD: begin
            phase_in = PHASE_FIRST;
            if (first_ff[BitXOvf] || first_ff[BitYOvf]) begin
               discarded = 1'b1;
            end else begin
               pos_x_in   = clamp_x;
               pos_y_in   = clamp_y;
               buttons_in = first_ff[2:0];
               applied    = 1'b1;
            end
         end
         default: begin
            // the unused phase code behaves as the first byte
            if (!rx_byte[BitSync]) begin
               ignored = 1'b1;
            end else begin
               first_in   = rx_byte;
               phase_in   = PHASE_SECOND;
               buttons_in = rx_byte[2:0];
            end
         end
      endcase

      result.cursor_x  = pos_x_in;
      result.cursor_y  = pos_y_in;
      result.buttons   = buttons_in;
      result.applied   = applied;
      result.discarded = discarded;
      result.ignored   = ignored;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_FIRST;
         first_ff   <= '0;
         second_ff  <= '0;
         pos_x_ff   <= ResetPosX;
         pos_y_ff   <= ResetPosY;
         buttons_ff <= '0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         first_ff   <= first_in;
         second_ff  <= second_in;
         pos_x_ff   <= pos_x_in;
         pos_y_ff   <= pos_y_in;
         buttons_ff <= buttons_in;
      end
   end

   a_third_closes: assert property (@(posedge clock) disable iff (reset)
      advance && phase_ff == PHASE_THIRD |=> phase_ff == PHASE_FIRST)
      else $error("packet not closed after third byte");

   a_ignore_holds: assert property (@(posedge clock) disable iff (reset)
      advance && ignored |=> phase_ff == PHASE_FIRST && $stable(buttons_ff))
      else $error("ignored byte changed packet state");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      advance |-> $onehot0({applied, discarded, ignored}))
      else $error("more than one status flag set");

   a_discard_keeps_pos: assert property (@(posedge clock) disable iff (reset)
      advance && discarded |=> $stable(pos_x_ff) && $stable(pos_y_ff))
      else $error("discarded packet moved the cursor");

endmodule

// ===== design/ps2_mouse_packet_tracker.sv =====
// Top level of the PS/2 mouse packet tracker: input register, decoder, result register.
// Depends on ps2mt_pkg and ps2mt_decoder.
//
//   channel   direction   payload
//   req_      in          tdata[7:0] rx_byte
//   rsp_      out         tdata: cursor_x, cursor_y, buttons; tuser: status flags
//   csr_      in          write only: 0 screen_width, 1 screen_height
//
// One byte a cycle sustained while rsp_tready stays high; the decoder's single pass loads the
// result register from the input register on advance, and the result shows on rsp_ from there.
// Reset (synchronous) empties both registers and restores position 40,12 and screen 1024x768.
// A stalled result holds its register; the input register still takes one more byte.
module ps2_mouse_packet_tracker #(
   parameter int CURSOR_W = ps2mt_pkg::DefCursorW,
   parameter int CURSOR_H = ps2mt_pkg::DefCursorH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [12:0] cursor_x, [25:13] cursor_y, [26] left_button,
                                    // [27] right_button, [28] middle_button, [31:29] zero
   output logic [2:0]  rsp_tuser,   // [0] packet_applied, [1] packet_discarded, [2] byte_ignored
   input  logic        csr_we,
   input  ps2mt_pkg::csr_index_type csr_index,
   input  logic [12:0] csr_wdata
);
   import ps2mt_pkg::*;

   logic              in_valid_ff;
   logic [7:0]        in_byte_ff;
   logic              out_valid_ff;
   result_type        out_ff;
   result_type        result;
   logic              advance;
   logic [CoordW-1:0] width_ff, height_ff;

   // move the held byte on whenever the result register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ResetWidth;
         height_ff <= ResetHeight;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata;
            CSR_SCREEN_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   ps2mt_decoder #(
      .CURSOR_W (CURSOR_W),
      .CURSOR_H (CURSOR_H)
   ) u_decoder (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .rx_byte       (in_byte_ff),
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_ff.buttons, out_ff.cursor_y, out_ff.cursor_x};
   assign rsp_tuser  = {out_ff.ignored, out_ff.discarded, out_ff.applied};

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_tready |-> !req_tready)
      else $error("byte accepted with both registers full");

   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("empty input register refused a byte");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result lost on advance");

endmodule
